[hdl/oil_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the ordered identifier list engine.
// Depends on nothing; every other file refers to it by scoped names.
package oil_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] entry_id;
    logic [31:0]        entry_score;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [31:0] found_score;
    logic [6:0]  entry_count;
  } out_rsp_t;

  typedef struct packed {
    logic signed [31:0] entry_id;
    logic [31:0]        entry_score;
  } entry_t;

endpackage

[hdl/ordered_id_list_engine.sv]
`timescale 1ns / 1ps
// An append writes its entry on acceptance and goes straight to the result state; the time a
// search or remove takes is set by the scan and the shift over the entry memory,
// which has one read and one write port and handles one entry per cycle.
// One request is in work at a time; the next is taken once the result enters the output
// register. Synchronous reset empties the list; stored entries are not cleared.
// Depends on oil_pkg and oil_out.
module ordered_id_list_engine #(
  parameter int CAPACITY = oil_pkg::DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  oil_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output oil_pkg::out_rsp_t out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         cmd_r, cmd_nxt;
  logic signed [31:0] id_r, id_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [IW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  oil_pkg::out_rsp_t  res_r, res_nxt;

  oil_pkg::entry_t    mem [CAPACITY];
  oil_pkg::entry_t    rd_data_r;
  oil_pkg::entry_t    wr_data;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic               rd_en;
  logic               push;
  logic               can_push;

  logic [IW:0]        idx_inc;
  logic [IW:0]        idx_inc2;
  logic [IW:0]        count_ext;

  assign idx_inc   = {1'b0, idx_r} + (IW + 1)'(1);
  assign idx_inc2  = {1'b0, idx_r} + (IW + 1)'(2);
  assign count_ext = (IW + 1)'(count_r);
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    id_nxt    = id_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    count_nxt = count_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = rd_data_r;
    rd_en     = 1'b0;
    rd_addr   = idx_inc[IW-1:0];
    push      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data.command;
          id_nxt  = in_data.entry_id;
          res_nxt.status      = oil_pkg::STATUS_NOT_FOUND;
          res_nxt.position    = '0;
          res_nxt.found_score = '0;
          res_nxt.entry_count = 7'(count_r);
          state_nxt = ST_RESP;
          case (in_data.command)
            oil_pkg::CMD_APPEND: begin
              if (count_r >= CW'(CAPACITY)) begin
                res_nxt.status = oil_pkg::STATUS_FULL;
              end else begin
                wr_en               = 1'b1;
                wr_addr             = count_r[IW-1:0];
                wr_data.entry_id    = in_data.entry_id;
                wr_data.entry_score = in_data.entry_score;
                count_nxt           = count_r + CW'(1);
                res_nxt.status      = oil_pkg::STATUS_DONE;
                res_nxt.entry_count = 7'(count_r + CW'(1));
              end
            end
            oil_pkg::CMD_SEARCH, oil_pkg::CMD_REMOVE: begin
              if (count_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_en = (idx_inc < count_ext);
        if (rd_data_r.entry_id == id_r) begin
          if (cmd_r == oil_pkg::CMD_SEARCH) begin
            res_nxt.status      = oil_pkg::STATUS_DONE;
            res_nxt.position    = 6'(idx_r);
            res_nxt.found_score = rd_data_r.entry_score;
            state_nxt           = ST_RESP;
          end else begin
            pos_nxt   = idx_r;
            state_nxt = ST_SHIFT;
          end
        end else if (idx_inc == count_ext) begin
          state_nxt = ST_RESP;
        end else begin
          idx_nxt = idx_inc[IW-1:0];
        end
      end
      ST_SHIFT: begin
        if (idx_inc < count_ext) begin
          wr_en   = 1'b1;
          idx_nxt = idx_inc[IW-1:0];
          rd_addr = idx_inc2[IW-1:0];
          rd_en   = (idx_inc2 < count_ext);
        end else begin
          count_nxt           = count_r - CW'(1);
          res_nxt.status      = oil_pkg::STATUS_DONE;
          res_nxt.position    = 6'(pos_r);
          res_nxt.entry_count = 7'(count_r - CW'(1));
          state_nxt           = ST_RESP;
        end
      end
      ST_RESP: begin
        if (can_push) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    cmd_r <= cmd_nxt;
    id_r  <= id_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  oil_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (res_r),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine ready again right after accepting a request");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == oil_pkg::CMD_APPEND
     && count_r < CW'(CAPACITY)) |=> (count_r == CW'($past(count_r) + CW'(1))))
    else $error("append did not grow the list by one");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_SHIFT) |-> ({1'b0, idx_r} < count_ext))
    else $error("scan index beyond the entry count");
`endif

endmodule

[hdl/oil_out.sv]
`timescale 1ns / 1ps
// Output register stage for the result channel of the list engine.
// Depends on oil_pkg for the result type.
module oil_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  oil_pkg::out_rsp_t push_data,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_ready,
  output oil_pkg::out_rsp_t out_data
);

  logic              valid_r;
  logic              valid_nxt;
  oil_pkg::out_rsp_t data_r;

  assign can_push  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (push) begin
      data_r <= push_data;
    end
  end

endmodule
